// ===== src/vrmm_pkg.sv =====
`default_nettype none

package vrmm_pkg;

    localparam int IDX_WIDTH = 10;
    localparam int LEN_WIDTH = 11;
    localparam logic [LEN_WIDTH-1:0] LEN_RESET = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic diff;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic writeback;
    } vrmm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_full;
    } vrmm_status_t;

endpackage

`default_nettype wire

// ===== src/vector_running_mean_merge_unit.sv =====
// Per-element running mean with merging of partial means.
// Input requests (in_valid/in_ready) carry one vector element: in add mode the
// element's stored mean moves towards the sample, in merge mode it absorbs a
// partial mean weighted by its own count. Every request yields one result
// request (out_valid/out_ready) with the new mean, the count in force and a
// flag set when the element closed the vector.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the vector
// length and is always ready; the user must write it only while the block is
// idle, and the block itself does not enforce this.
// Each request runs through the difference, multiply and divide steps, and
// no new request is taken until the last result is written back. A radix-2
// restoring divider retires one quotient bit per cycle, behind a split
// multiplier that forms the low and high partial products in turn.
// After reset the mean store is cleared one entry per cycle, and in_ready
// stays low until the clear is done.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and works on the next request and holds its finished result
// until the register is free.
`default_nettype none

module vector_running_mean_merge_unit #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int DATA_WIDTH   = 32,
    parameter int COUNT_WIDTH  = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vrmm_pkg::LEN_WIDTH-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           operation,
    input  wire logic [vrmm_pkg::IDX_WIDTH-1:0] element_index,
    input  wire logic signed [DATA_WIDTH-1:0]   value,
    input  wire logic [COUNT_WIDTH-1:0]         partial_count,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [vrmm_pkg::IDX_WIDTH-1:0]      result_index,
    output logic signed [DATA_WIDTH-1:0]        element_mean,
    output logic [COUNT_WIDTH-1:0]              total_count,
    output logic                                vector_done
);
    import vrmm_pkg::*;

    vrmm_cmd_t    cmd;
    vrmm_status_t status;

    vrmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vrmm_datapath #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .DATA_WIDTH   (DATA_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .element_index (element_index),
        .value         (value),
        .partial_count (partial_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_index  (result_index),
        .element_mean  (element_mean),
        .total_count   (total_count),
        .vector_done   (vector_done)
    );

endmodule

`default_nettype wire

// ===== src/vrmm_ctrl.sv =====
`default_nettype none

module vrmm_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire vrmm_pkg::vrmm_status_t status,
    output vrmm_pkg::vrmm_cmd_t         cmd
);
    import vrmm_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_WB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            S_IDLE:
            begin
                cmd.load = in_valid && in_ready_reg;
                if (in_valid && in_ready_reg)
                begin
                    state_next    = S_DIFF;
                    in_ready_next = 1'b0;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (!status.out_full)
                begin
                    cmd.writeback = 1'b1;
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_CLEAR;
                in_ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/vrmm_datapath.sv =====
`default_nettype none

module vrmm_datapath #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int DATA_WIDTH   = 32,
    parameter int COUNT_WIDTH  = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire vrmm_pkg::vrmm_cmd_t                   cmd,
    output vrmm_pkg::vrmm_status_t                     status,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [vrmm_pkg::LEN_WIDTH-1:0]        cfg_data,
    input  wire logic                                  operation,
    input  wire logic [vrmm_pkg::IDX_WIDTH-1:0]        element_index,
    input  wire logic signed [DATA_WIDTH-1:0]          value,
    input  wire logic [COUNT_WIDTH-1:0]                partial_count,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [vrmm_pkg::IDX_WIDTH-1:0]             result_index,
    output logic signed [DATA_WIDTH-1:0]               element_mean,
    output logic [COUNT_WIDTH-1:0]                     total_count,
    output logic                                       vector_done
);
    import vrmm_pkg::*;

    localparam int AW  = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int MW  = DATA_WIDTH + 1;
    localparam int LOW = 16;
    localparam int HW  = MW - LOW;
    localparam int MAW = (HW > LOW) ? HW : LOW;
    localparam int PW  = MW + COUNT_WIDTH;
    localparam int SW  = $clog2(MW + 1);

    logic [DATA_WIDTH-1:0]  mem [VECTOR_DEPTH];

    logic [LEN_WIDTH-1:0]   len_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [IDX_WIDTH-1:0]   idx_reg;
    logic [DATA_WIDTH-1:0]  x_reg;
    logic [COUNT_WIDTH-1:0] inc_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic                   in_store_reg;
    logic [AW-1:0]          addr_reg;
    logic [DATA_WIDTH-1:0]  rd_reg;
    logic [DATA_WIDTH-1:0]  mean_reg;
    logic [MW-1:0]          mag_reg;
    logic                   neg_reg;
    logic                   skip_reg;
    logic [PW-1:0]          acc_reg;
    logic [SW-1:0]          step_reg;
    logic [AW-1:0]          clr_reg;
    logic                   out_valid_reg;
    logic [IDX_WIDTH-1:0]   out_idx_reg;
    logic [DATA_WIDTH-1:0]  out_mean_reg;
    logic [COUNT_WIDTH-1:0] out_total_reg;
    logic                   out_done_reg;

    logic [31:0]            idx_wide;
    logic                   in_store_in;
    logic [AW-1:0]          addr_in;
    logic [COUNT_WIDTH-1:0] inc_in;
    logic [COUNT_WIDTH:0]   sum_in;
    logic [COUNT_WIDTH-1:0] total_in;
    logic [DATA_WIDTH-1:0]  mean_w;
    logic [MW-1:0]          diff_w;
    logic [MW-1:0]          mag_w;
    logic [MAW-1:0]         mul_a;
    logic [MAW+COUNT_WIDTH-1:0] mul_res;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   trial_sub;
    logic                   trial_ge;
    logic [COUNT_WIDTH-1:0] rem_next;
    logic [MW-1:0]          mean_ext;
    logic [MW-1:0]          nm_w;
    logic [DATA_WIDTH-1:0]  nm;
    logic                   done_w;

    assign cfg_ready = 1'b1;

    assign idx_wide    = 32'(element_index);
    assign in_store_in = idx_wide < 32'(VECTOR_DEPTH);
    assign addr_in     = idx_wide[AW-1:0];
    assign inc_in      = (operation == OP_MERGE) ? partial_count : COUNT_WIDTH'(1);
    assign sum_in      = {1'b0, count_reg} + {1'b0, inc_in};
    assign total_in    = sum_in[COUNT_WIDTH] ? '1 : sum_in[COUNT_WIDTH-1:0];

    assign mean_w = in_store_reg ? rd_reg : '0;
    assign diff_w = {x_reg[DATA_WIDTH-1], x_reg} - {mean_w[DATA_WIDTH-1], mean_w};
    assign mag_w  = diff_w[MW-1] ? (~diff_w + MW'(1)) : diff_w;

    assign mul_a   = cmd.mul_hi ? MAW'(mag_reg[MW-1:LOW]) : MAW'(mag_reg[LOW-1:0]);
    assign mul_res = mul_a * inc_reg;

    assign trial     = acc_reg[PW-1:MW-1];
    assign trial_sub = trial - {1'b0, total_reg};
    assign trial_ge  = trial >= {1'b0, total_reg};
    assign rem_next  = trial_ge ? trial_sub[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];

    assign mean_ext = {mean_reg[DATA_WIDTH-1], mean_reg};
    assign nm_w     = neg_reg ? (mean_ext - acc_reg[MW-1:0]) : (mean_ext + acc_reg[MW-1:0]);
    assign nm       = skip_reg ? mean_reg : nm_w[DATA_WIDTH-1:0];
    assign done_w   = (len_reg != '0) && ({1'b0, idx_reg} == (len_reg - LEN_WIDTH'(1)));

    assign status.clr_last = clr_reg == AW'(VECTOR_DEPTH - 1);
    assign status.div_last = step_reg == SW'(MW - 1);
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign result_index = out_idx_reg;
    assign element_mean = out_mean_reg;
    assign total_count  = out_total_reg;
    assign vector_done  = out_done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg <= mem[addr_in];
        end
        if (cmd.clr_step)
        begin
            mem[clr_reg] <= '0;
        end
        else if (cmd.writeback && in_store_reg)
        begin
            mem[addr_reg] <= nm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg      <= element_index;
            x_reg        <= value;
            inc_reg      <= inc_in;
            total_reg    <= total_in;
            in_store_reg <= in_store_in;
            addr_reg     <= addr_in;
        end
        if (cmd.diff)
        begin
            mean_reg <= mean_w;
            mag_reg  <= mag_w;
            neg_reg  <= diff_w[MW-1];
            skip_reg <= (total_reg == '0) || (inc_reg == '0);
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= PW'(mul_res);
        end
        else if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + (PW'(mul_res) << LOW);
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {rem_next, acc_reg[MW-2:0], trial_ge};
        end
        if (cmd.writeback)
        begin
            out_idx_reg   <= idx_reg;
            out_mean_reg  <= nm;
            out_total_reg <= total_reg;
            out_done_reg  <= done_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RESET;
            count_reg     <= '0;
            step_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.mul_hi)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + SW'(1);
            end
            if (cmd.writeback && done_w)
            begin
                count_reg <= total_reg;
            end
            if (cmd.writeback)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/vector_running_mean_merge_unit_tb.sv =====
`timescale 1ns / 100ps

module vector_running_mean_merge_unit_tb;

    import vrmm_pkg::*;

    localparam int VECTOR_DEPTH = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int COUNT_WIDTH  = 24;
    localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;
    localparam logic signed [DATA_WIDTH-1:0] MEAN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] MEAN_MIN = 32'sh8000_0000;

    typedef struct {
        logic [IDX_WIDTH-1:0]          idx;
        logic signed [DATA_WIDTH-1:0]  mean;
        logic [COUNT_WIDTH-1:0]        total;
        logic                          done;
    } mean_update_t;

    class mean_tracker;
        logic signed [DATA_WIDTH-1:0] means [VECTOR_DEPTH];
        longint                       vectors_absorbed;
        logic [LEN_WIDTH-1:0]         vec_len;
        mean_update_t                 updates_due [$];
        int                           mismatches;

        function new();
            foreach (means[i])
                means[i] = '0;
            vectors_absorbed = 0;
            vec_len = LEN_RESET;
            mismatches = 0;
        endfunction

        function void set_length(logic [LEN_WIDTH-1:0] len);
            vec_len = len;
        endfunction

        function void absorb_element(logic op, logic [IDX_WIDTH-1:0] idx,
                                     logic signed [DATA_WIDTH-1:0] x,
                                     logic [COUNT_WIDTH-1:0] n2);
            longint inc;
            longint total;
            longint old_mean;
            longint new_mean;
            longint diff;
            mean_update_t upd;
            inc = (op == OP_MERGE) ? longint'(n2) : 1;
            total = vectors_absorbed + inc;
            if (total > COUNT_MAX)
                total = COUNT_MAX;
            old_mean = longint'(means[idx]);
            new_mean = old_mean;
            if (total != 0 && inc != 0)
            begin
                diff = longint'(x) - old_mean;
                new_mean = old_mean + (diff * inc) / total;
            end
            means[idx] = new_mean[DATA_WIDTH-1:0];
            upd.idx   = idx;
            upd.mean  = new_mean[DATA_WIDTH-1:0];
            upd.total = total[COUNT_WIDTH-1:0];
            upd.done  = (vec_len != 0) && (LEN_WIDTH'(idx) == vec_len - 1'b1);
            if (upd.done)
                vectors_absorbed = total;
            updates_due.push_back(upd);
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_update(input logic [IDX_WIDTH-1:0] idx,
                          input logic signed [DATA_WIDTH-1:0] mean,
                          input logic [COUNT_WIDTH-1:0] total,
                          input logic done);
            mean_update_t want;
            if (updates_due.size() == 0)
            begin
                report_mismatch($sformatf("result for index %0d with no request outstanding",
                                          idx));
                return;
            end
            want = updates_due.pop_front();
            if (idx !== want.idx)
                report_mismatch($sformatf("result_index %0d, expected %0d", idx, want.idx));
            if (mean !== want.mean)
                report_mismatch($sformatf("element_mean %h, expected %h (index %0d)",
                                          mean, want.mean, want.idx));
            if (total !== want.total)
                report_mismatch($sformatf("total_count %0d, expected %0d (index %0d)",
                                          total, want.total, want.idx));
            if (done !== want.done)
                report_mismatch($sformatf("vector_done %b, expected %b (index %0d)",
                                          done, want.done, want.idx));
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [LEN_WIDTH-1:0]          cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          operation;
    logic [IDX_WIDTH-1:0]          element_index;
    logic signed [DATA_WIDTH-1:0]  value;
    logic [COUNT_WIDTH-1:0]        partial_count;
    logic                          out_valid;
    logic                          out_ready;
    logic [IDX_WIDTH-1:0]          result_index;
    logic signed [DATA_WIDTH-1:0]  element_mean;
    logic [COUNT_WIDTH-1:0]        total_count;
    logic                          vector_done;

    mean_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req = 1'b0;

    vector_running_mean_merge_unit #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .DATA_WIDTH   (DATA_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .element_index (element_index),
        .value         (value),
        .partial_count (partial_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_index  (result_index),
        .element_mean  (element_mean),
        .total_count   (total_count),
        .vector_done   (vector_done)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_update(result_index, element_mean, total_count, vector_done);
    end

    // The receiver holds off once for a long stretch so that the block fills up.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (600) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("** vector_running_mean_merge_unit: FAILED **");
        $finish;
    end

    task send_request(input logic op, input logic [IDX_WIDTH-1:0] idx,
                      input logic signed [DATA_WIDTH-1:0] x,
                      input logic [COUNT_WIDTH-1:0] n2);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        operation     = op;
        element_index = idx;
        value         = x;
        partial_count = n2;
        in_valid      = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.absorb_element(op, idx, x, n2);
    endtask

    task wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.updates_due.size() != 0)
            @(posedge clk);
        repeat (DATA_WIDTH + 10) @(posedge clk);
    endtask

    task write_length(input logic [LEN_WIDTH-1:0] len);
        @(negedge clk);
        cfg_data  = len;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_length(len);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task send_random_element(input logic [IDX_WIDTH-1:0] idx, input int vlen,
                             input bit big_counts);
        logic signed [DATA_WIDTH-1:0] x;
        logic [COUNT_WIDTH-1:0] n2;
        bit closing;
        closing = (vlen != 0) && (int'(idx) == vlen - 1);
        case ($urandom_range(7))
            0:       x = MEAN_MAX;
            1:       x = MEAN_MIN;
            2:       x = '0;
            default: x = $urandom;
        endcase
        if (closing && !big_counts)
            n2 = COUNT_WIDTH'($urandom_range(0, 15));
        else
            n2 = COUNT_WIDTH'($urandom);
        send_request($urandom_range(1) ? OP_MERGE : OP_ADD, idx, x, n2);
    endtask

    // Length 1-16: mostly full vectors in order, some cut short; else scattered.
    task run_random(input int n_items, input int vlen, input bit big_counts);
        int sent;
        int stop_at;
        logic [IDX_WIDTH-1:0] idx;
        sent = 0;
        while (sent < n_items)
        begin
            if (vlen >= 1 && vlen <= 16 && $urandom_range(99) < 80)
            begin
                stop_at = ($urandom_range(99) < 10) ? $urandom_range(0, vlen - 1) : vlen - 1;
                for (int i = 0; i <= stop_at; i++)
                begin
                    send_random_element(IDX_WIDTH'(i), vlen, big_counts);
                    sent++;
                end
            end
            else
            begin
                idx = ($urandom_range(3) == 0) ? IDX_WIDTH'(vlen - 1) : IDX_WIDTH'($urandom);
                send_random_element(idx, vlen, big_counts);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_ADD;
        element_index = '0;
        value         = '0;
        partial_count = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_length(11'd4);
        send_request(OP_MERGE, 10'd0, MEAN_MAX, 24'd0);
        send_request(OP_MERGE, 10'd3, 32'sd123, 24'd0);
        send_request(OP_ADD, 10'd0, MEAN_MAX, 24'd0);
        send_request(OP_ADD, 10'd1, MEAN_MIN, 24'd0);
        send_request(OP_ADD, 10'd2, -32'sd1, 24'hFF_FFFF);
        send_request(OP_ADD, 10'd3, 32'sh1234_5678, 24'd9);
        send_request(OP_MERGE, 10'd0, MEAN_MIN, 24'd3);
        send_request(OP_MERGE, 10'd1, MEAN_MAX, 24'd1);
        send_request(OP_MERGE, 10'd2, 32'sd0, 24'd0);
        send_request(OP_MERGE, 10'd3, 32'sd0, 24'd2);
        send_request(OP_ADD, 10'd1023, MEAN_MAX, 24'd0);
        send_request(OP_ADD, 10'd3, MEAN_MIN, 24'd0);
        wait_idle();

        send_idle_pct = 29;
        recv_idle_pct = 88;
        write_length(11'd8);
        run_random(250, 8, 1'b0);
        wait_idle();

        send_idle_pct = 88;
        recv_idle_pct = 29;
        write_length(11'd1);
        run_random(150, 1, 1'b0);
        wait_idle();
        write_length(11'd0);
        run_random(40, 0, 1'b0);
        wait_idle();
        write_length(11'd2047);
        run_random(40, 2047, 1'b0);
        wait_idle();
        write_length(LEN_RESET);
        run_random(40, 1024, 1'b0);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_length(11'd5);
        hold_off_req = 1'b1;
        run_random(250, 5, 1'b1);
        wait_idle();

        // Saturate the count, then keep updating against the saturated divisor.
        write_length(11'd1);
        send_request(OP_MERGE, 10'd0, MEAN_MAX, 24'hFF_FFFF);
        send_request(OP_ADD, 10'd0, MEAN_MIN, 24'd0);
        send_request(OP_MERGE, 10'd0, MEAN_MIN, 24'd5);
        send_request(OP_ADD, 10'd0, 32'sd0, 24'hFF_FFFF);
        wait_idle();

        if (tracker.updates_due.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.updates_due.size()));
        if (tracker.mismatches == 0)
            $display("** vector_running_mean_merge_unit: PASSED **");
        else
            $display("** vector_running_mean_merge_unit: FAILED **");
        $finish;
    end

endmodule
